// File: rtl/core/radial_lens_distortion_map_defines.svh
// Assertion macros shared by the radial lens distortion map RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef RADIAL_LENS_DISTORTION_MAP_DEFINES_SVH
`define RADIAL_LENS_DISTORTION_MAP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RLDM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rldm assertion failed");

// Next-cycle implication, disabled while reset is low.
`define RLDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rldm assertion failed");

`endif

// File: rtl/core/rldm_pkg.sv
// Package for the radial lens distortion map: widths, register indexes,
// fixed-point constants, shared types and rounding/saturation functions.
package rldm_pkg;

    localparam int COORD_W      = 32;
    localparam int NEWTON_STEPS = 4;
    localparam int TDATA_W      = ((2 * COORD_W + 7) / 8) * 8;
    localparam int CFG_IDX_W    = 8;

    localparam int MUL_LAT  = 4;
    localparam int DIV_BITS = 63;
    localparam int NW_DIV0  = 3 * MUL_LAT + 2;
    localparam int NW_LAT   = NW_DIV0 + DIV_BITS + 1;

    localparam int SH_SCALE = 8;
    localparam int SH_Q32   = 32;
    localparam int SH_COEF  = 28;
    localparam int SH_OUT   = 40;
    localparam int NEWTON_TRIPLE = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y     = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_R2    = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_R4    = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_SCALE_X = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_SCALE_Y = 8'd7;

    localparam logic [31:0] UNIT_SCALE = 32'h0100_0000;

    typedef logic signed [63:0] t_q32;

    localparam t_q32 ONE     = 64'sh0000_0001_0000_0000;
    localparam t_q32 SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_q32 A_LIM   = 64'sh0001_0000_0000_0000;
    localparam t_q32 S_LIM   = 64'sh0000_0004_0000_0000;
    localparam t_q32 CMAX    = (t_q32'(1) <<< (COORD_W - 1)) - t_q32'(1);
    localparam t_q32 CMIN    = -CMAX - t_q32'(1);

    typedef struct packed {
        logic                      req;
        logic                      byp;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        t_q32                      u;
        t_q32                      v;
    } t_pl;

    typedef struct packed {
        logic hold;
        t_q32 s;
        t_q32 a;
        t_pl  pl;
    } t_nw_io;

    function automatic t_q32 ext_coord(input logic [COORD_W-1:0] c);
        return t_q32'(signed'(c));
    endfunction

    // round half away from zero on the magnitude, shift, saturate, apply sign
    function automatic t_q32 rnd(input logic neg, input logic [127:0] prod, input int sh);
        logic [127:0] full;
        logic [127:0] q;
        logic [63:0]  m;
        full = prod + (128'd1 << (sh - 1));
        q    = full >> sh;
        if (|q[127:63]) begin
            m = SAT_MAX;
        end else begin
            m = q[63:0];
        end
        return neg ? -t_q32'(m) : t_q32'(m);
    endfunction

    function automatic t_q32 add_sat(input t_q32 a, input t_q32 b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(SAT_MAX)) begin
            return SAT_MAX;
        end
        if (s < -65'(SAT_MAX)) begin
            return -SAT_MAX;
        end
        return t_q32'(s[63:0]);
    endfunction

    function automatic t_q32 clamp(input t_q32 v, input t_q32 lo, input t_q32 hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

endpackage

// File: rtl/core/radial_lens_distortion_map.sv
// Top level of the radial lens distortion map: config registers, front and
// back pipelines, Newton chain and output skid; depends on rldm_pkg,
// rldm_mul, rldm_nstep and radial_lens_distortion_map_defines.svh.
//
// Maps one point per clock while not stalled, forward through 1 + k2*r^2 +
// k4*r^4 or inverse by NEWTON_STEPS Newton steps, all in 64-bit fixed point
// with saturation. Every item takes the same path, so results leave in order
// at one per cycle while not stalled; each Newton step holds a 63-stage
// restoring divider. Two results can be held when the output stalls; the
// input stalls only once the second holding slot is in use. Write
// configuration only while idle.
`include "radial_lens_distortion_map_defines.svh"

module radial_lens_distortion_map (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave: tdata = x_in, y_in; tuser = req_type
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [rldm_pkg::TDATA_W-1:0]      i_s_tdata,
    input  logic [0:0]                        i_s_tuser,
    // master: tdata = x_out, y_out; tuser = saturated
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [rldm_pkg::TDATA_W-1:0]      o_m_tdata,
    output logic [0:0]                        o_m_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rldm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    localparam int CW        = rldm_pkg::COORD_W;
    localparam int NS        = rldm_pkg::NEWTON_STEPS;
    localparam int ML        = rldm_pkg::MUL_LAT;
    localparam int P_UV      = ML;
    localparam int P_SQ      = 2 * ML;
    localparam int P_R2      = P_SQ + 1;
    localparam int P_BYP     = P_R2 + 1;
    localparam int P_K2      = P_R2 + ML;
    localparam int P_F1      = P_K2 + 1;
    localparam int P_K4      = P_K2 + ML;
    localparam int Q_W       = ML;
    localparam int Q_M       = 2 * ML;
    localparam int Q_LAST    = Q_M + 1;

    typedef struct packed {
        rldm_pkg::t_pl  pl;
        rldm_pkg::t_q32 dx;
        rldm_pkg::t_q32 dy;
        rldm_pkg::t_q32 uu;
        rldm_pkg::t_q32 vv;
        rldm_pkg::t_q32 r2;
        rldm_pkg::t_q32 k2r2;
        rldm_pkg::t_q32 r4;
        rldm_pkg::t_q32 f1;
        rldm_pkg::t_q32 a;
        rldm_pkg::t_q32 k4r4;
    } t_pre;

    typedef struct packed {
        rldm_pkg::t_pl        pl;
        rldm_pkg::t_q32       wx;
        rldm_pkg::t_q32       wy;
        rldm_pkg::t_q32       mx;
        rldm_pkg::t_q32       my;
        logic signed [CW-1:0] xo;
        logic signed [CW-1:0] yo;
        logic                 clip;
    } t_post;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 sat;
    } t_res;

    logic signed [31:0] r_cx, r_cy, r_k2, r_k4;
    logic [31:0]        r_sx, r_sy, r_ox, r_oy;

    t_pre              r_p [0:P_K4];
    logic [P_K4:0]     r_pv;
    t_pre              n_p0;
    rldm_pkg::t_nw_io  r_nin;
    logic              r_nin_vld;
    rldm_pkg::t_nw_io  n_nin;
    rldm_pkg::t_nw_io  w_nd [0:NS];
    logic              w_nv [0:NS];
    t_post             r_q [1:Q_LAST];
    logic [Q_LAST:1]   r_qv;
    t_post             n_q0;
    t_res              n_res;
    t_res              r_out, r_skid;
    logic              r_out_vld, r_skid_vld;

    logic              w_en, w_take;
    rldm_pkg::t_q32    w_cx, w_cy;
    rldm_pkg::t_q32    n_rx, n_ry;
    logic signed [CW-1:0] n_xo, n_yo;
    logic              n_clip;

    logic         w_u_neg, w_v_neg, w_uu_neg, w_vv_neg, w_k2_neg, w_r4_neg, w_k4_neg;
    logic         w_wx_neg, w_wy_neg, w_mx_neg, w_my_neg;
    logic [127:0] w_u_prod, w_v_prod, w_uu_prod, w_vv_prod, w_k2_prod, w_r4_prod;
    logic [127:0] w_k4_prod, w_wx_prod, w_wy_prod, w_mx_prod, w_my_prod;

    assign w_en        = !r_skid_vld;
    assign w_take      = r_out_vld && i_m_tready;
    assign o_s_tready  = w_en;
    assign o_cfg_ready = 1'b1;
    assign w_cx        = rldm_pkg::t_q32'(r_cx);
    assign w_cy        = rldm_pkg::t_q32'(r_cy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_sx <= rldm_pkg::UNIT_SCALE;
            r_sy <= rldm_pkg::UNIT_SCALE;
            r_k2 <= '0;
            r_k4 <= '0;
            r_ox <= rldm_pkg::UNIT_SCALE;
            r_oy <= rldm_pkg::UNIT_SCALE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rldm_pkg::REG_CENTER_X:    r_cx <= i_cfg_data;
                rldm_pkg::REG_CENTER_Y:    r_cy <= i_cfg_data;
                rldm_pkg::REG_SCALE_X:     r_sx <= i_cfg_data;
                rldm_pkg::REG_SCALE_Y:     r_sy <= i_cfg_data;
                rldm_pkg::REG_COEFF_R2:    r_k2 <= i_cfg_data;
                rldm_pkg::REG_COEFF_R4:    r_k4 <= i_cfg_data;
                rldm_pkg::REG_OUT_SCALE_X: r_ox <= i_cfg_data;
                rldm_pkg::REG_OUT_SCALE_Y: r_oy <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_p0        = '0;
        n_p0.pl.req = i_s_tuser[0];
        n_p0.pl.x   = i_s_tdata[CW-1:0];
        n_p0.pl.y   = i_s_tdata[2*CW-1:CW];
        n_p0.dx     = rldm_pkg::ext_coord(i_s_tdata[CW-1:0]) - w_cx;
        n_p0.dy     = rldm_pkg::ext_coord(i_s_tdata[2*CW-1:CW]) - w_cy;
    end

    rldm_mul u_mul_u (.i_clk(i_clk), .i_en(w_en), .i_a(r_p[0].dx),
        .i_b(rldm_pkg::t_q32'({32'd0, r_sx})), .o_neg(w_u_neg), .o_prod(w_u_prod));
    rldm_mul u_mul_v (.i_clk(i_clk), .i_en(w_en), .i_a(r_p[0].dy),
        .i_b(rldm_pkg::t_q32'({32'd0, r_sy})), .o_neg(w_v_neg), .o_prod(w_v_prod));
    rldm_mul u_mul_uu (.i_clk(i_clk), .i_en(w_en), .i_a(r_p[P_UV].pl.u),
        .i_b(r_p[P_UV].pl.u), .o_neg(w_uu_neg), .o_prod(w_uu_prod));
    rldm_mul u_mul_vv (.i_clk(i_clk), .i_en(w_en), .i_a(r_p[P_UV].pl.v),
        .i_b(r_p[P_UV].pl.v), .o_neg(w_vv_neg), .o_prod(w_vv_prod));
    rldm_mul u_mul_k2 (.i_clk(i_clk), .i_en(w_en), .i_a(rldm_pkg::t_q32'(r_k2)),
        .i_b(r_p[P_R2].r2), .o_neg(w_k2_neg), .o_prod(w_k2_prod));
    rldm_mul u_mul_r4 (.i_clk(i_clk), .i_en(w_en), .i_a(r_p[P_R2].r2),
        .i_b(r_p[P_R2].r2), .o_neg(w_r4_neg), .o_prod(w_r4_prod));
    rldm_mul u_mul_k4 (.i_clk(i_clk), .i_en(w_en), .i_a(rldm_pkg::t_q32'(r_k4)),
        .i_b(r_p[P_K2].r4), .o_neg(w_k4_neg), .o_prod(w_k4_prod));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv      <= '0;
            r_nin_vld <= 1'b0;
            r_qv      <= '0;
        end else if (w_en) begin
            r_pv      <= {r_pv[P_K4-1:0], i_s_tvalid};
            r_nin_vld <= r_pv[P_K4];
            r_qv      <= {r_qv[Q_LAST-1:1], w_nv[NS]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p[0] <= n_p0;
            for (int i = 1; i <= P_K4; i++) begin
                r_p[i] <= r_p[i-1];
            end
            r_p[P_UV].pl.u <= rldm_pkg::rnd(w_u_neg, w_u_prod, rldm_pkg::SH_SCALE);
            r_p[P_UV].pl.v <= rldm_pkg::rnd(w_v_neg, w_v_prod, rldm_pkg::SH_SCALE);
            r_p[P_SQ].uu   <= rldm_pkg::rnd(w_uu_neg, w_uu_prod, rldm_pkg::SH_Q32);
            r_p[P_SQ].vv   <= rldm_pkg::rnd(w_vv_neg, w_vv_prod, rldm_pkg::SH_Q32);
            r_p[P_R2].r2   <= rldm_pkg::add_sat(r_p[P_SQ].uu, r_p[P_SQ].vv);
            r_p[P_BYP].pl.byp <= r_p[P_R2].pl.req && (r_p[P_R2].r2 == '0 || r_k2 == '0);
            r_p[P_K2].k2r2 <= rldm_pkg::rnd(w_k2_neg, w_k2_prod, rldm_pkg::SH_COEF);
            r_p[P_K2].r4   <= rldm_pkg::rnd(w_r4_neg, w_r4_prod, rldm_pkg::SH_Q32);
            r_p[P_F1].f1   <= rldm_pkg::add_sat(rldm_pkg::ONE, r_p[P_K2].k2r2);
            r_p[P_F1].a    <= rldm_pkg::clamp(r_p[P_K2].k2r2, -rldm_pkg::A_LIM,
                                              rldm_pkg::A_LIM);
            r_p[P_K4].k4r4 <= rldm_pkg::rnd(w_k4_neg, w_k4_prod, rldm_pkg::SH_COEF);
            r_nin <= n_nin;
        end
    end

    always_comb begin
        n_nin.pl   = r_p[P_K4].pl;
        n_nin.a    = r_p[P_K4].a;
        n_nin.hold = !r_p[P_K4].pl.req || r_p[P_K4].pl.byp;
        n_nin.s    = r_p[P_K4].pl.req ? rldm_pkg::ONE
                   : rldm_pkg::add_sat(r_p[P_K4].f1, r_p[P_K4].k4r4);
    end

    assign w_nd[0] = r_nin;
    assign w_nv[0] = r_nin_vld;

    for (genvar g = 0; g < NS; g++) begin : g_newton
        rldm_nstep u_nstep (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_vld(w_nv[g]), .i_d(w_nd[g]),
            .o_vld(w_nv[g+1]), .o_d(w_nd[g+1])
        );
    end

    always_comb begin
        n_q0    = '0;
        n_q0.pl = w_nd[NS].pl;
    end

    rldm_mul u_mul_wx (.i_clk(i_clk), .i_en(w_en), .i_a(w_nd[NS].pl.u),
        .i_b(w_nd[NS].s), .o_neg(w_wx_neg), .o_prod(w_wx_prod));
    rldm_mul u_mul_wy (.i_clk(i_clk), .i_en(w_en), .i_a(w_nd[NS].pl.v),
        .i_b(w_nd[NS].s), .o_neg(w_wy_neg), .o_prod(w_wy_prod));
    rldm_mul u_mul_mx (.i_clk(i_clk), .i_en(w_en), .i_a(r_q[Q_W].wx),
        .i_b(rldm_pkg::t_q32'({32'd0, r_ox})), .o_neg(w_mx_neg), .o_prod(w_mx_prod));
    rldm_mul u_mul_my (.i_clk(i_clk), .i_en(w_en), .i_a(r_q[Q_W].wy),
        .i_b(rldm_pkg::t_q32'({32'd0, r_oy})), .o_neg(w_my_neg), .o_prod(w_my_prod));

    always_comb begin
        n_rx   = rldm_pkg::add_sat(r_q[Q_M].mx, w_cx);
        n_ry   = rldm_pkg::add_sat(r_q[Q_M].my, w_cy);
        n_clip = 1'b0;
        n_xo   = n_rx[CW-1:0];
        n_yo   = n_ry[CW-1:0];
        if (n_rx > rldm_pkg::CMAX) begin
            n_xo = rldm_pkg::CMAX[CW-1:0];
            n_clip = 1'b1;
        end else if (n_rx < rldm_pkg::CMIN) begin
            n_xo = rldm_pkg::CMIN[CW-1:0];
            n_clip = 1'b1;
        end
        if (n_ry > rldm_pkg::CMAX) begin
            n_yo = rldm_pkg::CMAX[CW-1:0];
            n_clip = 1'b1;
        end else if (n_ry < rldm_pkg::CMIN) begin
            n_yo = rldm_pkg::CMIN[CW-1:0];
            n_clip = 1'b1;
        end
        if (r_q[Q_M].pl.byp) begin
            n_xo   = r_q[Q_M].pl.x;
            n_yo   = r_q[Q_M].pl.y;
            n_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q[1] <= n_q0;
            for (int i = 2; i <= Q_LAST; i++) begin
                r_q[i] <= r_q[i-1];
            end
            r_q[Q_W].wx <= rldm_pkg::rnd(w_wx_neg, w_wx_prod, rldm_pkg::SH_Q32);
            r_q[Q_W].wy <= rldm_pkg::rnd(w_wy_neg, w_wy_prod, rldm_pkg::SH_Q32);
            r_q[Q_M].mx <= rldm_pkg::rnd(w_mx_neg, w_mx_prod, rldm_pkg::SH_OUT);
            r_q[Q_M].my <= rldm_pkg::rnd(w_my_neg, w_my_prod, rldm_pkg::SH_OUT);
            r_q[Q_LAST].xo   <= n_xo;
            r_q[Q_LAST].yo   <= n_yo;
            r_q[Q_LAST].clip <= n_clip;
        end
    end

    always_comb begin
        n_res.x   = r_q[Q_LAST].xo;
        n_res.y   = r_q[Q_LAST].yo;
        n_res.sat = r_q[Q_LAST].clip;
    end

    // hold a finished request in the skid slot while the output is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_en) begin
            if (!r_out_vld || w_take) begin
                r_out_vld <= r_qv[Q_LAST];
            end else if (r_qv[Q_LAST]) begin
                r_skid_vld <= 1'b1;
            end
        end else if (w_take) begin
            r_out_vld  <= 1'b1;
            r_skid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!r_out_vld || w_take) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end else if (w_take) begin
            r_out <= r_skid;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = rldm_pkg::TDATA_W'({r_out.y, r_out.x});
    assign o_m_tuser  = r_out.sat;

    `RLDM_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_vld, r_out_vld)
    `RLDM_ASSERT_NEXT(a_stall_freezes, i_clk, i_rst_n, !w_en, $stable(r_qv))
    `RLDM_ASSERT_NEXT(a_stall_to_skid, i_clk, i_rst_n, w_en && r_qv[Q_LAST] && r_out_vld && !w_take, r_skid_vld)
    `RLDM_ASSERT_IMPL(a_sat_at_edge, i_clk, i_rst_n, r_out_vld && r_out.sat, r_out.x == rldm_pkg::CMAX[CW-1:0] || r_out.x == rldm_pkg::CMIN[CW-1:0] || r_out.y == rldm_pkg::CMAX[CW-1:0] || r_out.y == rldm_pkg::CMIN[CW-1:0])

endmodule

// File: rtl/core/rldm_mul.sv
// Three-stage signed 64x64 multiplier built from four 32x32 partial products.
// Returns sign and 128-bit magnitude; depends on rldm_pkg.
module rldm_mul (
    input  logic           i_clk,
    input  logic           i_en,
    input  rldm_pkg::t_q32 i_a,
    input  rldm_pkg::t_q32 i_b,
    output logic           o_neg,
    output logic [127:0]   o_prod
);

    logic         r_neg1;
    logic         r_neg2;
    logic         r_neg3;
    logic [63:0]  r_ma;
    logic [63:0]  r_mb;
    logic [63:0]  r_p00;
    logic [63:0]  r_p01;
    logic [63:0]  r_p10;
    logic [63:0]  r_p11;
    logic [127:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg1 <= i_a[63] ^ i_b[63];
            r_ma   <= i_a[63] ? 64'(-i_a) : 64'(i_a);
            r_mb   <= i_b[63] ? 64'(-i_b) : 64'(i_b);
            r_neg2 <= r_neg1;
            r_p00  <= r_ma[31:0]  * r_mb[31:0];
            r_p01  <= r_ma[31:0]  * r_mb[63:32];
            r_p10  <= r_ma[63:32] * r_mb[31:0];
            r_p11  <= r_ma[63:32] * r_mb[63:32];
            r_neg3 <= r_neg2;
            r_prod <= {r_p11, r_p00} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0};
        end
    end

    assign o_neg  = r_neg3;
    assign o_prod = r_prod;

endmodule

// File: rtl/core/rldm_nstep.sv
// One pipelined Newton step for s in a*s^3 + s - 1 = 0, with a bit-per-stage
// restoring divider; depends on rldm_pkg and rldm_mul.
module rldm_nstep (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  rldm_pkg::t_nw_io i_d,
    output logic             o_vld,
    output rldm_pkg::t_nw_io o_d
);

    localparam int I_S2  = rldm_pkg::MUL_LAT;
    localparam int I_S3  = 2 * rldm_pkg::MUL_LAT;
    localparam int I_AS3 = 3 * rldm_pkg::MUL_LAT;
    localparam int I_NUM = I_AS3 + 1;
    localparam int I_D0  = rldm_pkg::NW_DIV0;
    localparam int LAT   = rldm_pkg::NW_LAT;

    typedef struct packed {
        rldm_pkg::t_nw_io io;
        rldm_pkg::t_q32   s2;
        rldm_pkg::t_q32   s3;
        rldm_pkg::t_q32   m3a;
        rldm_pkg::t_q32   as3;
        rldm_pkg::t_q32   num;
        rldm_pkg::t_q32   den;
        logic             neg;
        logic             ovf;
        logic [63:0]      rem;
        logic [62:0]      w;
    } t_nc;

    t_nc          r_c [1:LAT];
    logic [LAT:1] r_v;
    t_nc          n_c0;

    logic [63:0] n_trial [I_D0+1:LAT-1];
    logic [63:0] n_rem   [I_D0+1:LAT-1];
    logic [62:0] n_w     [I_D0+1:LAT-1];

    logic           w_s2_neg, w_s3_neg, w_3a_neg, w_as3_neg;
    logic [127:0]   w_s2_prod, w_s3_prod, w_3a_prod, w_as3_prod;
    rldm_pkg::t_q32 w_a3;
    logic [63:0]    n_un;
    rldm_pkg::t_q32 n_q;
    rldm_pkg::t_q32 n_quot;
    rldm_pkg::t_q32 n_sfin;

    assign w_a3 = r_c[I_S2].io.a * rldm_pkg::t_q32'(rldm_pkg::NEWTON_TRIPLE);

    rldm_mul u_mul_s2 (
        .i_clk(i_clk), .i_en(i_en), .i_a(i_d.s), .i_b(i_d.s),
        .o_neg(w_s2_neg), .o_prod(w_s2_prod)
    );
    rldm_mul u_mul_s3 (
        .i_clk(i_clk), .i_en(i_en), .i_a(r_c[I_S2].s2), .i_b(r_c[I_S2].io.s),
        .o_neg(w_s3_neg), .o_prod(w_s3_prod)
    );
    rldm_mul u_mul_3a (
        .i_clk(i_clk), .i_en(i_en), .i_a(w_a3), .i_b(r_c[I_S2].s2),
        .o_neg(w_3a_neg), .o_prod(w_3a_prod)
    );
    rldm_mul u_mul_as3 (
        .i_clk(i_clk), .i_en(i_en), .i_a(r_c[I_S3].io.a), .i_b(r_c[I_S3].s3),
        .o_neg(w_as3_neg), .o_prod(w_as3_prod)
    );

    always_comb begin
        n_c0    = '0;
        n_c0.io = i_d;
    end

    always_comb begin
        for (int i = I_D0 + 1; i < LAT; i++) begin
            n_trial[i] = {r_c[i-1].rem[62:0], r_c[i-1].w[62]};
            if (n_trial[i] >= $unsigned(r_c[i-1].den)) begin
                n_rem[i] = n_trial[i] - $unsigned(r_c[i-1].den);
                n_w[i]   = {r_c[i-1].w[61:0], 1'b1};
            end else begin
                n_rem[i] = n_trial[i];
                n_w[i]   = {r_c[i-1].w[61:0], 1'b0};
            end
        end
    end

    assign n_un = r_c[I_NUM].num[63] ? 64'(-r_c[I_NUM].num) : 64'(r_c[I_NUM].num);

    always_comb begin
        n_q    = r_c[LAT-1].ovf ? rldm_pkg::SAT_MAX : rldm_pkg::t_q32'({1'b0, r_c[LAT-1].w});
        n_quot = r_c[LAT-1].neg ? -n_q : n_q;
        if (r_c[LAT-1].io.hold) begin
            n_sfin = r_c[LAT-1].io.s;
        end else if (r_c[LAT-1].den > 0) begin
            n_sfin = rldm_pkg::clamp(rldm_pkg::add_sat(r_c[LAT-1].io.s, -n_quot),
                                     '0, rldm_pkg::S_LIM);
        end else begin
            n_sfin = rldm_pkg::clamp(r_c[LAT-1].io.s, '0, rldm_pkg::S_LIM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[LAT-1:1], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c[1] <= n_c0;
            for (int i = 2; i <= LAT; i++) begin
                r_c[i] <= r_c[i-1];
            end
            r_c[I_S2].s2  <= rldm_pkg::rnd(w_s2_neg, w_s2_prod, rldm_pkg::SH_Q32);
            r_c[I_S3].s3  <= rldm_pkg::rnd(w_s3_neg, w_s3_prod, rldm_pkg::SH_Q32);
            r_c[I_S3].m3a <= rldm_pkg::rnd(w_3a_neg, w_3a_prod, rldm_pkg::SH_Q32);
            r_c[I_AS3].as3 <= rldm_pkg::rnd(w_as3_neg, w_as3_prod, rldm_pkg::SH_Q32);
            r_c[I_NUM].num <= rldm_pkg::add_sat(
                rldm_pkg::add_sat(r_c[I_AS3].as3, r_c[I_AS3].io.s), -rldm_pkg::ONE);
            r_c[I_NUM].den <= rldm_pkg::add_sat(r_c[I_AS3].m3a, rldm_pkg::ONE);
            r_c[I_D0].neg <= r_c[I_NUM].num[63];
            r_c[I_D0].ovf <= {31'd0, n_un[63:31]} >= $unsigned(r_c[I_NUM].den);
            r_c[I_D0].rem <= {31'd0, n_un[63:31]};
            r_c[I_D0].w   <= {n_un[30:0], 32'd0};
            for (int i = I_D0 + 1; i < LAT; i++) begin
                r_c[i].rem <= n_rem[i];
                r_c[i].w   <= n_w[i];
            end
            r_c[LAT].io.s <= n_sfin;
        end
    end

    assign o_vld = r_v[LAT];
    assign o_d   = r_c[LAT].io;

endmodule
